// ===== rtl/imm_pkg.sv =====
// shared types, constants and codes for the int16 matrix multiplier
package imm_pkg;

  // fixed field widths
  localparam int IDX_W       = 3;
  localparam int VAL_W       = 16;
  localparam int SIZE_W      = 4;
  localparam int OPCODE_W    = 2;

  // defaults for the top level parameter and the size register
  localparam int DIM_DEFAULT = 8;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  // command queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // input opcodes
  localparam logic [OPCODE_W-1:0] OP_WRITE_A  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WRITE_B  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_MULTIPLY = 2'd2;

  // input word
  typedef struct packed {
    logic [OPCODE_W-1:0]    opcode;
    logic [IDX_W-1:0]       row_index;
    logic [IDX_W-1:0]       col_index;
    logic signed [VAL_W-1:0] element_value;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [VAL_W-1:0] product_value;
    logic [IDX_W-1:0]       out_row;
    logic [IDX_W-1:0]       out_col;
    logic                   last_element;
  } out_word_t;

  // classified command kinds
  typedef enum logic [1:0] {
    CMD_WRITE_A,
    CMD_WRITE_B,
    CMD_MULTIPLY
  } cmd_kind_t;

  // queued command
  typedef struct packed {
    cmd_kind_t              kind;
    logic [IDX_W-1:0]       row;
    logic [IDX_W-1:0]       col;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  // back end status seen by the top level
  typedef struct packed {
    logic mul_active;
    logic pop;
  } back_status_t;

endpackage

// ===== rtl/imm_front.sv =====
// front end: accepts input words and classifies them into queue commands
module imm_front #(
  parameter int MAX_DIM = imm_pkg::DIM_DEFAULT
) (
  input  logic            start,
  input  logic            busy,
  input  imm_pkg::in_word_t item,
  output logic            push,
  output imm_pkg::cmd_t   cmd
);
  import imm_pkg::*;

  logic accept;
  logic in_range;
  logic keep;

  // word taken when the queue has room
  assign accept = start && !busy;

  // element writes outside the stores are dropped
  assign in_range = (32'(item.row_index) < MAX_DIM) && (32'(item.col_index) < MAX_DIM);

  // classify the opcode; the unused code is dropped; payload passes as it is
  always_comb begin
    keep      = 1'b0;
    cmd.kind  = CMD_WRITE_A;
    cmd.row   = item.row_index;
    cmd.col   = item.col_index;
    cmd.value = item.element_value;
    case (item.opcode)
      OP_WRITE_A: begin
        keep     = in_range;
        cmd.kind = CMD_WRITE_A;
      end
      OP_WRITE_B: begin
        keep     = in_range;
        cmd.kind = CMD_WRITE_B;
      end
      OP_MULTIPLY: begin
        keep     = 1'b1;
        cmd.kind = CMD_MULTIPLY;
      end
      default: begin
        keep     = 1'b0;
        cmd.kind = CMD_WRITE_A;
      end
    endcase
  end

  assign push = accept && keep;

endmodule

// ===== rtl/imm_queue.sv =====
// short command queue between front and back
module imm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  imm_pkg::cmd_t push_cmd,
  input  logic          pop,
  output imm_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);
  import imm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] level;

  assign empty = (level == CNT_W'(0));
  assign full  = (level == CNT_W'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        level <= level + CNT_W'(1);
      end else if (pop && !push) begin
        level <= level - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/imm_back.sv =====
// back end: element stores and one multiply-accumulate pipeline
module imm_back #(
  parameter int MAX_DIM = imm_pkg::DIM_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  imm_pkg::cmd_t               head,
  input  logic                        empty,
  input  logic [imm_pkg::SIZE_W-1:0]  matrix_size,
  output imm_pkg::back_status_t       status,
  output logic                        result_strobe,
  output imm_pkg::out_word_t          result
);
  import imm_pkg::*;

  localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_MUL
  } state_t;

  typedef struct packed {
    logic             first;
    logic             last;
    logic             final_elem;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

  state_t           state;
  logic [IDX_W-1:0] cnt_i;
  logic [IDX_W-1:0] cnt_j;
  logic [IDX_W-1:0] cnt_k;
  logic [IDX_W-1:0] dim_m1;

  logic             pop;
  logic             we_a;
  logic             we_b;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;
  logic [SIZE_W-1:0] size_eff;

  logic [VAL_W-1:0] mem_a [MEM_DEPTH];
  logic [VAL_W-1:0] mem_b [MEM_DEPTH];
  logic signed [VAL_W-1:0] rd_a;
  logic signed [VAL_W-1:0] rd_b;

  tag_t             tag_issue;
  logic             valid1;
  tag_t             tag1;
  logic             valid2;
  tag_t             tag2;
  logic signed [2*VAL_W-1:0] prod_full;
  logic [VAL_W-1:0] prod;
  logic [VAL_W-1:0] acc;
  logic [VAL_W-1:0] acc_next;

  // take a command only between multiplies
  assign pop  = (state == ST_IDLE) && !empty;
  assign we_a = pop && (head.kind == CMD_WRITE_A);
  assign we_b = pop && (head.kind == CMD_WRITE_B);

  assign status.mul_active = (state == ST_MUL);
  assign status.pop        = pop;

  // store addresses, row-major at the full store width
  assign wr_addr   = ADDR_W'(head.row) * ADDR_W'(MAX_DIM) + ADDR_W'(head.col);
  assign rd_addr_a = ADDR_W'(cnt_i) * ADDR_W'(MAX_DIM) + ADDR_W'(cnt_k);
  assign rd_addr_b = ADDR_W'(cnt_k) * ADDR_W'(MAX_DIM) + ADDR_W'(cnt_j);

  // size in use, held within 1 .. MAX_DIM
  always_comb begin
    size_eff = matrix_size;
    if (matrix_size == '0) begin
      size_eff = SIZE_W'(1);
    end else if (32'(matrix_size) > MAX_DIM) begin
      size_eff = SIZE_W'(MAX_DIM);
    end
  end

  // store a: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wr_addr] <= head.value;
    end
    rd_a <= mem_a[rd_addr_a];
  end

  // store b: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[wr_addr] <= head.value;
    end
    rd_b <= mem_b[rd_addr_b];
  end

  // sequencer over i, j, k
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt_i  <= '0;
      cnt_j  <= '0;
      cnt_k  <= '0;
      dim_m1 <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop && (head.kind == CMD_MULTIPLY)) begin
            state  <= ST_MUL;
            cnt_i  <= '0;
            cnt_j  <= '0;
            cnt_k  <= '0;
            dim_m1 <= IDX_W'(size_eff - SIZE_W'(1));
          end
        end
        ST_MUL: begin
          if (cnt_k == dim_m1) begin
            cnt_k <= '0;
            if (cnt_j == dim_m1) begin
              cnt_j <= '0;
              if (cnt_i == dim_m1) begin
                cnt_i <= '0;
                state <= ST_IDLE;
              end else begin
                cnt_i <= cnt_i + IDX_W'(1);
              end
            end else begin
              cnt_j <= cnt_j + IDX_W'(1);
            end
          end else begin
            cnt_k <= cnt_k + IDX_W'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // tag that travels with each read pair
  assign tag_issue.first      = (cnt_k == '0);
  assign tag_issue.last       = (cnt_k == dim_m1);
  assign tag_issue.final_elem = (cnt_i == dim_m1) && (cnt_j == dim_m1);
  assign tag_issue.row        = cnt_i;
  assign tag_issue.col        = cnt_j;

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
    end else begin
      valid1 <= (state == ST_MUL);
      valid2 <= valid1;
    end
  end

  // multiply stage, low half kept since the sum wraps at 16 bits
  assign prod_full = rd_a * rd_b;

  always_ff @(posedge clk) begin
    tag1 <= tag_issue;
    tag2 <= tag1;
    prod <= prod_full[VAL_W-1:0];
  end

  // accumulate stage
  assign acc_next = (tag2.first ? '0 : acc) + prod;

  always_ff @(posedge clk) begin
    if (valid2) begin
      acc <= acc_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= valid2 && tag2.last;
    end
  end

  always_ff @(posedge clk) begin
    if (valid2 && tag2.last) begin
      result.product_value <= acc_next;
      result.out_row       <= tag2.row;
      result.out_col       <= tag2.col;
      result.last_element  <= tag2.final_elem;
    end
  end

endmodule

// ===== rtl/int16_matrix_multiply.sv =====
// top level of the signed 16-bit square matrix multiplier
//
//  port group            dir  handshake         word
//  start/busy/item       in   start & !busy     in_word_t (opcode, row, col, element)
//  result_strobe/result  out  strobe, no stall  out_word_t (product, row, col, last)
//  cfg_wr_en/cfg_wr_data in   write enable      matrix_size, 4 bits
//
//  Element writes are taken one per cycle while busy is low; the back end retires one a cycle between multiplies.
//  A multiply runs on the single multiply-accumulate unit (one read of each
//  store per cycle); its results come one per element in row-major order,
//  and the next command waits until the sequencer has stepped through every
//  i, j and k.
//  busy rises while the two-entry command queue is full.
//  Reset clears control state only; the stores hold garbage until written.
//  The receiver cannot stall: each result is on the ports for one cycle.
module int16_matrix_multiply #(
  parameter int MAX_DIM = imm_pkg::DIM_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  imm_pkg::in_word_t           item,
  input  logic                        cfg_wr_en,
  input  logic [imm_pkg::SIZE_W-1:0]  cfg_wr_data,
  output logic                        result_strobe,
  output imm_pkg::out_word_t          result
);
  import imm_pkg::*;

  logic                 q_push;
  cmd_t                 q_push_cmd;
  cmd_t                 q_head;
  logic                 q_empty;
  logic                 q_full;
  logic [SIZE_W-1:0]    matrix_size;
  back_status_t         back_st;

  // size register
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      matrix_size <= cfg_wr_data;
    end
  end

  // stall the sender while the queue is full
  assign busy = q_full;

  // front end
  imm_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .start (start),
    .busy  (busy),
    .item  (item),
    .push  (q_push),
    .cmd   (q_push_cmd)
  );

  // command queue
  imm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (back_st.pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // back end
  imm_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_head),
    .empty         (q_empty),
    .matrix_size   (matrix_size),
    .status        (back_st),
    .result_strobe (result_strobe),
    .result        (result)
  );

  // the back end never takes a command in the middle of a multiply
  assert property (@(posedge clk) disable iff (rst) back_st.mul_active |-> !back_st.pop)
    else $error("command popped during multiply");

  // a full queue cannot be empty, and busy means something waits
  assert property (@(posedge clk) disable iff (rst) busy |-> !q_empty)
    else $error("busy with an empty queue");

  // the final element sits on the diagonal
  assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.last_element) |-> (result.out_row == result.out_col))
    else $error("final element off the diagonal");

  // a result word cannot appear with no multiply behind it
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_strobe) |-> $past(back_st.mul_active, 3))
    else $error("result without a multiply");

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the int16 matrix multiplier: directed table then random phases
`timescale 1ns / 1ps

module testbench;
  import imm_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int DIM          = DIM_DEFAULT;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 140;
  localparam int END_WAIT     = 5000;
  localparam int PRINT_CAP    = 20;

  // one row of the directed table: a size write or an input word
  typedef struct packed {
    bit                  is_cfg;
    logic [SIZE_W-1:0]   size;
    in_word_t            word;
    bit                  typed;
    logic [VAL_W-1:0]    want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  in_word_t           item;
  logic               cfg_wr_en;
  logic [SIZE_W-1:0]  cfg_wr_data;
  logic               result_strobe;
  out_word_t          result;

  // local copy of the stores and the size register
  logic signed [VAL_W-1:0] a_mat [DIM][DIM];
  logic signed [VAL_W-1:0] b_mat [DIM][DIM];
  bit                      a_set [DIM][DIM];
  bit                      b_set [DIM][DIM];
  logic [SIZE_W-1:0]       size_reg;

  out_word_t pending_products [$];
  dir_row_t  dir_rows [$];

  int mismatch_count  = 0;
  int items_sent      = 0;
  int multiplies_sent = 0;
  int words_checked   = 0;
  int largest_dim     = 0;
  int sender_idle_pct = 0;
  int rand_items      = 0;

  int16_matrix_multiply #(.MAX_DIM(DIM)) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .result_strobe (result_strobe),
    .result        (result)
  );

  always #10 clk = ~clk;

  // hard stop well beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  task automatic report_mismatch(string what);
    if (mismatch_count < PRINT_CAP) begin
      $display("testbench: mismatch at %0t: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  // n in use: zero acts as one, anything past the store size acts as the store size
  function automatic int active_dim();
    int n;
    n = size_reg;
    if (n < 1) n = 1;
    if (n > DIM) n = DIM;
    return n;
  endfunction

  function automatic in_word_t make_word(logic [OPCODE_W-1:0] op, int r, int c,
                                         logic [VAL_W-1:0] v);
    in_word_t w;
    w.opcode        = op;
    w.row_index     = IDX_W'(r);
    w.col_index     = IDX_W'(c);
    w.element_value = v;
    return w;
  endfunction

  // update the stores, or work out every product word a multiply emits
  // (row and column are three bits wide, so no write can fall outside the store)
  function automatic void compute_products(in_word_t w);
    int n;
    int av;
    int bv;
    int prod;
    logic [VAL_W-1:0] acc;
    out_word_t o;
    case (w.opcode)
      OP_WRITE_A: begin
        a_mat[w.row_index][w.col_index] = w.element_value;
        a_set[w.row_index][w.col_index] = 1'b1;
      end
      OP_WRITE_B: begin
        b_mat[w.row_index][w.col_index] = w.element_value;
        b_set[w.row_index][w.col_index] = 1'b1;
      end
      OP_MULTIPLY: begin
        n = active_dim();
        for (int i = 0; i < n; i++) begin
          for (int j = 0; j < n; j++) begin
            acc = '0;
            for (int k = 0; k < n; k++) begin
              av   = a_mat[i][k];
              bv   = b_mat[k][j];
              prod = av * bv;
              acc  = acc + prod[VAL_W-1:0];
            end
            o.product_value = acc;
            o.out_row       = IDX_W'(i);
            o.out_col       = IDX_W'(j);
            o.last_element  = (i == n - 1) && (j == n - 1);
            pending_products.push_back(o);
          end
        end
      end
      default: begin
        // unused opcode: dropped by the block
      end
    endcase
  endfunction

  // drive one word, wait for it to be taken, record what it should produce
  task automatic send_word(in_word_t w, bit typed, logic [VAL_W-1:0] want);
    out_word_t o;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= w;
    @(negedge clk);
    while (busy) @(negedge clk);
    if (typed) begin
      o.product_value = want;
      o.out_row       = '0;
      o.out_col       = '0;
      o.last_element  = 1'b1;
      pending_products.push_back(o);
    end else begin
      compute_products(w);
    end
    if (w.opcode == OP_MULTIPLY) multiplies_sent++;
    items_sent++;
    @(posedge clk);
  endtask

  // random words: sender idling follows how far the random part has got
  task automatic send_random(in_word_t w);
    if (rand_items < RANDOM_ITEMS / 3) sender_idle_pct = 32;
    else if (rand_items < 2 * RANDOM_ITEMS / 3) sender_idle_pct = 58;
    else sender_idle_pct = 0;
    send_word(w, 1'b0, '0);
    if (w.opcode != OP_UNUSED) rand_items++;
  endtask

  // wait for every pending word, then let queued writes retire
  task automatic settle();
    start <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(logic [SIZE_W-1:0] s);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= s;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    size_reg = s;
    if (active_dim() > largest_dim) largest_dim = active_dim();
  endtask

  function automatic void add_row(bit is_cfg, logic [SIZE_W-1:0] s, logic [OPCODE_W-1:0] op,
                                  int r, int c, int v, bit typed, int want);
    dir_row_t row;
    row.is_cfg = is_cfg;
    row.size   = s;
    row.word   = make_word(op, r, c, VAL_W'(v));
    row.typed  = typed;
    row.want   = VAL_W'(want);
    dir_rows.push_back(row);
  endfunction

  // random element value with the extremes turning up often
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // check each product word against the oldest pending one
  always @(negedge clk) begin : product_check
    out_word_t want;
    if (!rst && result_strobe === 1'b1) begin
      words_checked++;
      if (pending_products.size() == 0) begin
        report_mismatch($sformatf("product word C[%0d][%0d] = %0d with none pending",
                                  result.out_row, result.out_col,
                                  $signed(result.product_value)));
      end else begin
        want = pending_products.pop_front();
        if (result.product_value !== want.product_value || result.out_row !== want.out_row ||
            result.out_col !== want.out_col || result.last_element !== want.last_element) begin
          report_mismatch($sformatf("got C[%0d][%0d] = %0d last %b, want C[%0d][%0d] = %0d last %b",
                                    result.out_row, result.out_col,
                                    $signed(result.product_value), result.last_element,
                                    want.out_row, want.out_col,
                                    $signed(want.product_value), want.last_element));
        end
      end
    end
  end

  initial begin : stimulus
    logic [SIZE_W-1:0] s;
    int n;
    int pick;
    int code;
    int wait_cycles;
    int holes [$];
    bit big_full_done;
    bit big_other_done;

    rst         = 1'b1;
    start       = 1'b0;
    item        = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    size_reg    = SIZE_RESET;
    big_full_done  = 1'b0;
    big_other_done = 1'b0;

    // directed: single elements at the extremes, typed results
    add_row(1, 4'd1, OP_WRITE_A, 0, 0, 0, 0, 0);
    add_row(0, 0, OP_WRITE_A, 0, 0, 32767, 0, 0);
    add_row(0, 0, OP_WRITE_B, 0, 0, 32767, 0, 0);
    add_row(0, 0, OP_MULTIPLY, 0, 0, 0, 1, 1);
    add_row(0, 0, OP_WRITE_A, 0, 0, -32768, 0, 0);
    add_row(0, 0, OP_WRITE_B, 0, 0, -32768, 0, 0);
    add_row(0, 0, OP_MULTIPLY, 0, 0, 0, 1, 0);
    add_row(0, 0, OP_WRITE_B, 0, 0, 32767, 0, 0);
    // unused opcode must leave the stores alone
    add_row(0, 0, OP_UNUSED, 7, 7, -1, 0, 0);
    // size zero behaves as one
    add_row(1, 4'd0, OP_WRITE_A, 0, 0, 0, 0, 0);
    add_row(0, 0, OP_MULTIPLY, 0, 0, 0, 1, -32768);
    // two by two, checked against the predictor
    add_row(1, 4'd2, OP_WRITE_A, 0, 0, 0, 0, 0);
    add_row(0, 0, OP_WRITE_A, 0, 1, -1, 0, 0);
    add_row(0, 0, OP_WRITE_A, 1, 0, 1, 0, 0);
    add_row(0, 0, OP_WRITE_A, 1, 1, 32767, 0, 0);
    add_row(0, 0, OP_WRITE_B, 0, 1, -32768, 0, 0);
    add_row(0, 0, OP_WRITE_B, 1, 0, -1, 0, 0);
    add_row(0, 0, OP_WRITE_B, 1, 1, 12345, 0, 0);
    add_row(0, 0, OP_MULTIPLY, 0, 0, 0, 0, 0);
    // writes at the top corner, outside the active size
    add_row(0, 0, OP_WRITE_A, 7, 7, -1, 0, 0);
    add_row(0, 0, OP_WRITE_B, 7, 0, 21845, 0, 0);
    add_row(0, 0, OP_UNUSED, 0, 0, 0, 0, 0);
    add_row(0, 0, OP_MULTIPLY, 0, 0, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) set_size(dir_rows[r].size);
      else send_word(dir_rows[r].word, dir_rows[r].typed, dir_rows[r].want);
    end

    // random phases: pick a size, fill any unwritten corner entries, then multiply
    while (rand_items < RANDOM_ITEMS) begin
      if (!big_full_done && rand_items >= 60) begin
        s = 4'd15;
        big_full_done = 1'b1;
      end else if (!big_other_done && rand_items >= 130) begin
        s = SIZE_W'($urandom_range(8, 14));
        big_other_done = 1'b1;
      end else if ($urandom_range(3) == 0) begin
        s = SIZE_W'($urandom_range(5, 7));
      end else begin
        s = SIZE_W'($urandom_range(0, 4));
      end
      set_size(s);
      n = active_dim();

      // no multiply may read an entry that was never written
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          if (!a_set[i][j]) holes.push_back(i * DIM + j);
          if (!b_set[i][j]) holes.push_back(DIM * DIM + i * DIM + j);
        end
      end
      while (holes.size() != 0) begin
        pick = $urandom_range(holes.size() - 1);
        code = holes[pick];
        holes.delete(pick);
        send_random(make_word(code >= DIM * DIM ? OP_WRITE_B : OP_WRITE_A,
                              (code / DIM) % DIM, code % DIM, pick_value()));
      end

      repeat ((n == DIM) ? $urandom_range(1, 2) : $urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 4)) begin
          case ($urandom_range(5))
            0: send_random(make_word(OP_UNUSED, $urandom_range(7), $urandom_range(7),
                                     VAL_W'($urandom)));
            1: send_random(make_word($urandom_range(1) ? OP_WRITE_B : OP_WRITE_A,
                                     $urandom_range(7), $urandom_range(7), pick_value()));
            default: send_random(make_word($urandom_range(1) ? OP_WRITE_B : OP_WRITE_A,
                                           $urandom_range(n - 1), $urandom_range(n - 1),
                                           pick_value()));
          endcase
        end
        send_random(make_word(OP_MULTIPLY, $urandom_range(7), $urandom_range(7),
                              VAL_W'($urandom)));
      end
    end

    // drain: every pending word must arrive within a bounded wait
    start <= 1'b0;
    wait_cycles = 0;
    while (pending_products.size() != 0 && wait_cycles < END_WAIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (pending_products.size() != 0) begin
      report_mismatch($sformatf("%0d product words never arrived", pending_products.size()));
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("testbench: %0d words sent, %0d multiplies, %0d product words checked",
             items_sent, multiplies_sent, words_checked);
    $display("testbench: sizes up to %0d x %0d, %0d mismatches",
             largest_dim, largest_dim, mismatch_count);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
